// ===== sv/rmlw_pkg.sv =====
`default_nettype none

package rmlw_pkg;

    // request actions
    localparam logic [1:0] ACT_TRYLOCK = 2'd0;
    localparam logic [1:0] ACT_LOCK    = 2'd1;
    localparam logic [1:0] ACT_UNLOCK  = 2'd2;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_BUSY      = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_FULL      = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    // waiter stack control, lock core to stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // waiter stack flags, stack to lock core
    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_flags;

endpackage

`default_nettype wire

// ===== sv/rmlw_req_if.sv =====
`default_nettype none

interface rmlw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] thread_id;

    modport source (output valid, output action, output thread_id, input ready);
    modport sink   (input valid, input action, input thread_id, output ready);
endinterface

`default_nettype wire

// ===== sv/rmlw_rsp_if.sv =====
`default_nettype none

interface rmlw_rsp_if;
    logic              valid;
    logic              ready;
    rmlw_pkg::t_status status;
    logic              wake_valid;
    logic [7:0]        wake_thread;

    modport source (output valid, output status, output wake_valid, output wake_thread,
                    input ready);
    modport sink   (input valid, input status, input wake_valid, input wake_thread,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/rmlw_stack.sv =====
`default_nettype none

module rmlw_stack #(
    parameter int ID_BITS    = 8,
    parameter int WAIT_DEPTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  rmlw_pkg::t_stk_ctl     i_ctl,
    input  wire  [ID_BITS-1:0]     i_data,
    output rmlw_pkg::t_stk_flags   o_flags,
    output logic [ID_BITS-1:0]     o_top
);

    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int IDX_W = $clog2(WAIT_DEPTH);

    logic [ID_BITS-1:0] r_mem [WAIT_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   n_below;
    logic [ID_BITS-1:0] r_top;
    logic [ID_BITS-1:0] r_next;

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == CNT_W'(WAIT_DEPTH));
    assign o_top         = r_top;

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        n_below = n_count - CNT_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // entry below the top is prefetched so a pop can refill the top next cycle;
    // the write of a push never hits the prefetch address
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_data;
        end
        if (n_count >= CNT_W'(2)) begin
            r_next <= r_mem[n_below[IDX_W-1:0]];
        end
        if (i_ctl.push) begin
            r_top <= i_data;
        end else if (i_ctl.pop) begin
            r_top <= r_next;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_flags.full)
        else $error("push into full waiter stack");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_flags.empty)
        else $error("pop from empty waiter stack");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("push and pop in one cycle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("count did not advance on push");

endmodule

`default_nettype wire

// ===== sv/recursive_mutex_lifo_waiters_top.sv =====
// Channel | Dir | Payload                                | Transaction
// i_req   | in  | action[1:0], thread_id[7:0]            | valid && ready
// o_rsp   | out | status[2:0], wake_valid, wake_thread   | valid && ready
//
// One request per cycle; each result appears in the output register in the cycle
// after its request is taken, set by the single owner/count/stack-top update.
// i_req.ready is high while the output register is empty or being drained.
// A stalled result holds the output register and stops further requests.
// Reset clears owner, hold count, waiter count and output valid; stack
// entries stay unwritten until pushed.
`default_nettype none

module recursive_mutex_lifo_waiters_top #(
    parameter int ID_BITS    = 8,
    parameter int COUNT_BITS = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rmlw_req_if.sink    i_req,
    rmlw_rsp_if.source  o_rsp
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [ID_BITS-1:0]     r_owner;
    logic [ID_BITS-1:0]     n_owner;
    logic [COUNT_BITS-1:0]  r_hold;
    logic [COUNT_BITS-1:0]  n_hold;
    logic                   r_valid;
    rmlw_pkg::t_status      r_status;
    rmlw_pkg::t_status      n_status;
    logic                   r_wake_valid;
    logic                   n_wake_valid;
    logic [7:0]             r_wake_thread;
    logic [7:0]             n_wake_thread;

    logic                   accept;
    logic [ID_BITS-1:0]     tid;
    logic                   is_owner;
    logic                   is_free;
    rmlw_pkg::t_stk_ctl     stk_ctl;
    rmlw_pkg::t_stk_flags   stk_flags;
    logic [ID_BITS-1:0]     stk_top;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign tid         = ID_BITS'(i_req.thread_id);
    assign is_owner    = (r_owner == tid);
    assign is_free     = (r_owner == '0);

    always_comb begin
        n_owner       = r_owner;
        n_hold        = r_hold;
        n_status      = rmlw_pkg::ST_BUSY;
        n_wake_valid  = 1'b0;
        n_wake_thread = '0;
        stk_ctl       = '0;
        case (i_req.action)
            rmlw_pkg::ACT_TRYLOCK, rmlw_pkg::ACT_LOCK: begin
                if (tid == '0) begin
                    n_status = rmlw_pkg::ST_BUSY;
                end else if (is_owner) begin
                    if (r_hold == COUNT_MAX) begin
                        n_status = rmlw_pkg::ST_SATURATED;
                    end else begin
                        n_hold   = r_hold + COUNT_BITS'(1);
                        n_status = rmlw_pkg::ST_GRANTED;
                    end
                end else if (is_free) begin
                    n_owner  = tid;
                    n_hold   = COUNT_BITS'(1);
                    n_status = rmlw_pkg::ST_GRANTED;
                end else if (i_req.action == rmlw_pkg::ACT_TRYLOCK) begin
                    n_status = rmlw_pkg::ST_BUSY;
                end else if (stk_flags.full) begin
                    n_status = rmlw_pkg::ST_FULL;
                end else begin
                    stk_ctl.push = accept;
                    n_status     = rmlw_pkg::ST_QUEUED;
                end
            end
            rmlw_pkg::ACT_UNLOCK: begin
                if (is_free || !is_owner) begin
                    n_status = rmlw_pkg::ST_NOT_OWNER;
                end else if (r_hold > COUNT_BITS'(1)) begin
                    n_hold   = r_hold - COUNT_BITS'(1);
                    n_status = rmlw_pkg::ST_GRANTED;
                end else if (!stk_flags.empty) begin
                    // hand the lock to the newest waiter
                    stk_ctl.pop   = accept;
                    n_owner       = stk_top;
                    n_hold        = COUNT_BITS'(1);
                    n_status      = rmlw_pkg::ST_GRANTED;
                    n_wake_valid  = 1'b1;
                    n_wake_thread = 8'(stk_top);
                end else begin
                    n_owner  = '0;
                    n_hold   = '0;
                    n_status = rmlw_pkg::ST_GRANTED;
                end
            end
            default: begin
                n_status = rmlw_pkg::ST_BUSY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_hold  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_owner <= n_owner;
                r_hold  <= n_hold;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_wake_valid  <= n_wake_valid;
            r_wake_thread <= n_wake_thread;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.wake_valid  = r_wake_valid;
    assign o_rsp.wake_thread = r_wake_thread;

    rmlw_stack #(
        .ID_BITS    (ID_BITS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .i_data  (tid),
        .o_flags (stk_flags),
        .o_top   (stk_top)
    );

    a_wake_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.wake_valid) |-> (o_rsp.status == rmlw_pkg::ST_GRANTED))
        else $error("wakeup without grant");

    a_free_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owner == '0) == (r_hold == '0))
        else $error("owner and hold count disagree");

    a_wait_needs_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_ctl.push |=> (r_owner != '0))
        else $error("waiter queued on a free lock");

endmodule

`default_nettype wire

// ===== test/recursive_mutex_lifo_waiters_chk.sv =====
`default_nettype none

module recursive_mutex_lifo_waiters_chk #(
    parameter int COUNT_BITS = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rmlw_req_if        i_req,
    rmlw_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output logic [7:0] o_owner_hint
);

    typedef struct packed {
        rmlw_pkg::t_status status;
        logic              wake_valid;
        logic [7:0]        wake_thread;
    } t_lock_rsp;

    // lock state as the block should hold it
    logic [7:0]            exp_owner;
    logic [COUNT_BITS-1:0] hold_cnt;
    logic [7:0]            waiters [WAIT_DEPTH];
    int                    n_waiters;

    t_lock_rsp lock_rsp_q [$];
    int        fail_cnt;
    int        rsp_seen;

    assign o_fail_count = fail_cnt;

    initial begin
        fail_cnt  = 0;
        rsp_seen  = 0;
    end

    function automatic t_lock_rsp apply_request(input logic [1:0] act, input logic [7:0] tid);
        t_lock_rsp r;
        r.status      = rmlw_pkg::ST_GRANTED;
        r.wake_valid  = 1'b0;
        r.wake_thread = '0;
        case (act)
            rmlw_pkg::ACT_TRYLOCK, rmlw_pkg::ACT_LOCK: begin
                if (tid == '0) begin
                    r.status = rmlw_pkg::ST_BUSY;
                end else if (tid == exp_owner) begin
                    // recursive acquire, stick at the top of the count
                    if (hold_cnt == '1) begin
                        r.status = rmlw_pkg::ST_SATURATED;
                    end else begin
                        hold_cnt = hold_cnt + 1'b1;
                    end
                end else if (exp_owner == '0) begin
                    exp_owner = tid;
                    hold_cnt  = COUNT_BITS'(1);
                end else if (act == rmlw_pkg::ACT_TRYLOCK) begin
                    r.status = rmlw_pkg::ST_BUSY;
                end else if (n_waiters >= WAIT_DEPTH) begin
                    r.status = rmlw_pkg::ST_FULL;
                end else begin
                    waiters[n_waiters] = tid;
                    n_waiters++;
                    r.status = rmlw_pkg::ST_QUEUED;
                end
            end
            rmlw_pkg::ACT_UNLOCK: begin
                if (exp_owner == '0 || exp_owner != tid) begin
                    r.status = rmlw_pkg::ST_NOT_OWNER;
                end else if (hold_cnt > 1) begin
                    hold_cnt = hold_cnt - 1'b1;
                end else if (n_waiters > 0) begin
                    // hand over to the newest waiter
                    n_waiters--;
                    exp_owner     = waiters[n_waiters];
                    hold_cnt      = COUNT_BITS'(1);
                    r.wake_valid  = 1'b1;
                    r.wake_thread = exp_owner;
                end else begin
                    exp_owner = '0;
                    hold_cnt  = '0;
                end
            end
            default: begin
                r.status = rmlw_pkg::ST_BUSY;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("ERROR: response %0d: %s expected %0d got %0d",
                 rsp_seen, what, exp_val, got_val);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_lock_rsp exp_rsp;
        if (!i_rst_n) begin
            exp_owner = '0;
            hold_cnt  = '0;
            n_waiters = 0;
            lock_rsp_q.delete();
        end else begin
            // queue the prediction first so the oldest entry is always the match
            if (i_req.valid && i_req.ready) begin
                lock_rsp_q.push_back(apply_request(i_req.action, i_req.thread_id));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (lock_rsp_q.size() == 0) begin
                    report_mismatch("unexpected transaction, status", -1, int'(i_rsp.status));
                end else begin
                    exp_rsp = lock_rsp_q.pop_front();
                    if (i_rsp.status !== exp_rsp.status) begin
                        report_mismatch("status", int'(exp_rsp.status), int'(i_rsp.status));
                    end
                    if (i_rsp.wake_valid !== exp_rsp.wake_valid) begin
                        report_mismatch("wake_valid", int'(exp_rsp.wake_valid),
                                        int'(i_rsp.wake_valid));
                    end
                    if (i_rsp.wake_thread !== exp_rsp.wake_thread) begin
                        report_mismatch("wake_thread", int'(exp_rsp.wake_thread),
                                        int'(i_rsp.wake_thread));
                    end
                end
                rsp_seen++;
            end
        end
        o_pending    <= lock_rsp_q.size();
        o_owner_hint <= exp_owner;
    end

endmodule

`default_nettype wire

// ===== test/recursive_mutex_lifo_waiters_top_tb.sv =====
`default_nettype none

module recursive_mutex_lifo_waiters_top_tb;

    localparam int         COUNT_BITS      = 16;
    localparam int         WAIT_DEPTH      = 16;
    localparam int         RANDOM_ITEMS    = 1400;
    localparam int         QUIET_ITEMS     = 150;
    localparam int         HOLD_OFF_CYCLES = 120;
    localparam int         CYCLE_LIMIT     = 1_000_000;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmlw_req_if req_if ();
    rmlw_rsp_if rsp_if ();

    int         fail_cnt;
    int         pending;
    logic [7:0] owner_hint;

    bit idle_on;
    int hold_off_reqs;
    int hold_off_seen;
    int stall_left;
    int cycle_cnt;

    recursive_mutex_lifo_waiters_top #(
        .COUNT_BITS (COUNT_BITS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    recursive_mutex_lifo_waiters_chk #(
        .COUNT_BITS (COUNT_BITS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_cnt),
        .o_pending    (pending),
        .o_owner_hint (owner_hint)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached with %0d responses outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // response side: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (hold_off_seen != hold_off_reqs) begin
            hold_off_seen++;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [7:0] tid);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.action    <= act;
        req_if.thread_id <= tid;
        // hold until the transaction is taken
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic run_directed();
        // free lock, thread zero and the unused action
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h05);
        send_req(rmlw_pkg::ACT_TRYLOCK, 8'h00);
        send_req(rmlw_pkg::ACT_LOCK, 8'h00);
        send_req(ACT_UNUSED, 8'hFF);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h00);
        // ownership, recursion, waiting and handover
        send_req(rmlw_pkg::ACT_TRYLOCK, 8'hFF);
        send_req(rmlw_pkg::ACT_TRYLOCK, 8'h01);
        send_req(rmlw_pkg::ACT_LOCK, 8'hFF);
        send_req(rmlw_pkg::ACT_LOCK, 8'h01);
        send_req(rmlw_pkg::ACT_LOCK, 8'h80);
        send_req(rmlw_pkg::ACT_LOCK, 8'h01);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h01);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'hFF);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'hFF);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h01);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h80);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h01);
        send_req(rmlw_pkg::ACT_UNLOCK, 8'h01);
        // fill the waiter stack past its depth, then drain newest first
        send_req(rmlw_pkg::ACT_LOCK, 8'hAA);
        for (int k = 0; k <= WAIT_DEPTH; k++) begin
            send_req(rmlw_pkg::ACT_LOCK, 8'(8'h40 + k));
        end
        send_req(rmlw_pkg::ACT_UNLOCK, 8'hAA);
        for (int k = WAIT_DEPTH - 1; k >= 0; k--) begin
            send_req(rmlw_pkg::ACT_UNLOCK, 8'(8'h40 + k));
        end
    endtask

    task automatic run_random();
        logic [7:0] pool [4];
        bit         lock_heavy;
        int         r;
        int         wt;
        logic [1:0] act;
        logic [7:0] tid;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                foreach (pool[k]) pool[k] = 8'($urandom_range(1, 255));
                lock_heavy = ($urandom_range(0, 3) == 0);
                idle_on    = (i < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_on = 1'b0;
            end
            if (i == 100 || i == 700) begin
                hold_off_reqs++;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                act = ACT_UNUSED;
                tid = 8'($urandom_range(0, 255));
            end else if (r < 6) begin
                act = 2'($urandom_range(0, 2));
                tid = '0;
            end else if (r < 12) begin
                act = 2'($urandom_range(0, 2));
                tid = 8'($urandom_range(1, 255));
            end else begin
                wt = $urandom_range(0, 99);
                if (wt < 20) begin
                    act = rmlw_pkg::ACT_TRYLOCK;
                end else if (wt < (lock_heavy ? 85 : 55)) begin
                    act = rmlw_pkg::ACT_LOCK;
                end else begin
                    act = rmlw_pkg::ACT_UNLOCK;
                end
                tid = pool[$urandom_range(0, 3)];
                // steer toward the current owner so the lock keeps moving
                if (owner_hint != '0 &&
                    $urandom_range(0, 99) < ((act == rmlw_pkg::ACT_UNLOCK) ? 80 : 25)) begin
                    tid = owner_hint;
                end
            end
            send_req(act, tid);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.action    = rmlw_pkg::ACT_TRYLOCK;
        req_if.thread_id = '0;
        rsp_if.ready     = 1'b0;
        idle_on          = 1'b1;
        hold_off_reqs    = 0;
        hold_off_seen    = 0;
        stall_left       = 0;
        cycle_cnt        = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        idle_on = 1'b0;
        run_random();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
